// ===== design/bresenham_line_rasterizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Bresenham line rasterizer assertion macros
// Concurrent check helpers; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BLR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blr assertion failed");

// next-cycle implication
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blr assertion failed");

`else

`define BLR_ASSERT_IMP(label, clk, rst, ante, cons)
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types, screen constants and pixel placement for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;

  localparam int CW = 6;

  localparam logic [CW:0] X_MAX = (CW+1)'(SCREEN_WIDTH - 1);
  localparam logic [CW:0] Y_MAX = (CW+1)'(SCREEN_HEIGHT - 1);

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic emit;
  } blr_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } blr_status_t;

  // mirror then clamp to 0..max
  function automatic coord_t place(input coord_t v, input logic mirror,
                                   input logic [CW:0] max);
    logic signed [CW+1:0] t;
    logic signed [CW+1:0] lim;
    lim = $signed({1'b0, max});
    if (mirror) begin
      t = lim - $signed({2'b00, v});
    end else begin
      t = $signed({2'b00, v});
    end
    if (t < 0) begin
      t = '0;
    end
    if (t > lim) begin
      t = lim;
    end
    return t[CW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/blr_ctrl.sv =====
// ----------------------------------------------------------------------------
// blr_ctrl
// Line walk controller: takes a command, then steps one pixel per free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire blr_pkg::blr_status_t status,
  output blr_pkg::blr_cmd_t        cmd
);
  import blr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_stall = (state != S_IDLE);
  assign cmd.load = in_valid && (state == S_IDLE);
  assign cmd.emit = (state == S_RUN) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.emit && status.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/blr_datapath.sv =====
// ----------------------------------------------------------------------------
// blr_datapath
// Point, error term and endpoint registers, orientation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire blr_pkg::blr_cmd_t   cmd,
  output blr_pkg::blr_status_t     status,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_wdata,
  input  wire logic                kind,
  input  wire blr_pkg::coord_t     start_x,
  input  wire blr_pkg::coord_t     start_y,
  input  wire blr_pkg::coord_t     end_x,
  input  wire blr_pkg::coord_t     end_y,
  input  wire logic                ink,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output blr_pkg::coord_t          pixel_x,
  output blr_pkg::coord_t          pixel_y,
  output logic                     pixel_ink,
  output logic                     final_pixel
);
  import blr_pkg::*;

  logic [1:0]            orientation;
  coord_t                prev_x;
  coord_t                prev_y;
  coord_t                x;
  coord_t                y;
  coord_t                x1;
  coord_t                y1;
  coord_t                dx;
  coord_t                dy;
  logic                  sx;
  logic                  sy;
  logic signed [CW+2:0]  err;
  logic                  ink_r;

  coord_t                x0_sel;
  coord_t                y0_sel;
  logic signed [CW+3:0]  e2;
  logic                  step_x;
  logic                  step_y;
  logic                  last;

  assign x0_sel = kind ? prev_x : start_x;
  assign y0_sel = kind ? prev_y : start_y;

  assign last   = (x == x1) && (y == y1);
  assign e2     = {err, 1'b0};
  assign step_x = e2 > -$signed({4'b0000, dy});
  assign step_y = e2 < $signed({4'b0000, dx});

  assign status.last     = last;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        orientation <= cfg_wdata;
      end
      if (cmd.load) begin
        prev_x <= end_x;
        prev_y <= end_y;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= x0_sel;
      y     <= y0_sel;
      x1    <= end_x;
      y1    <= end_y;
      dx    <= (end_x > x0_sel) ? end_x - x0_sel : x0_sel - end_x;
      dy    <= (end_y > y0_sel) ? end_y - y0_sel : y0_sel - end_y;
      sx    <= x0_sel < end_x;
      sy    <= y0_sel < end_y;
      err   <= $signed({3'b000, ((end_x > x0_sel) ? end_x - x0_sel : x0_sel - end_x)})
             - $signed({3'b000, ((end_y > y0_sel) ? end_y - y0_sel : y0_sel - end_y)});
      ink_r <= ink;
    end else if (cmd.emit) begin
      if (step_x) begin
        x <= sx ? x + 1'b1 : x - 1'b1;
      end
      if (step_y) begin
        y <= sy ? y + 1'b1 : y - 1'b1;
      end
      err <= err - (step_x ? $signed({3'b000, dy}) : '0)
                 + (step_y ? $signed({3'b000, dx}) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x     <= place(x, orientation[0], X_MAX);
      pixel_y     <= place(y, orientation[1], Y_MAX);
      pixel_ink   <= ink_r;
      final_pixel <= last;
    end
  end

endmodule

`default_nettype wire

// ===== design/bresenham_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Line command in, stream of mirrored pixel writes out.
// ----------------------------------------------------------------------------
// A line command is taken while idle, then the line is walked one pixel per
// cycle, except while the output stalls, into a registered output; no new
// command is taken until the last pixel is emitted. The walk runs in a
// single Bresenham step unit updated once per emitted pixel. A kind 1 command
// starts at the unmirrored end point of the previous line. The last pixel of
// every line carries final_pixel. orientation may only be written while idle.
`default_nettype none

`include "bresenham_line_rasterizer_top_assert.svh"

module bresenham_line_rasterizer_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            kind,
  input  wire blr_pkg::coord_t start_x,
  input  wire blr_pkg::coord_t start_y,
  input  wire blr_pkg::coord_t end_x,
  input  wire blr_pkg::coord_t end_y,
  input  wire logic            ink,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output blr_pkg::coord_t      pixel_x,
  output blr_pkg::coord_t      pixel_y,
  output logic                 pixel_ink,
  output logic                 final_pixel
);
  import blr_pkg::*;

  blr_cmd_t    cmd;
  blr_status_t status;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  blr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .kind        (kind),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .ink         (ink),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_ink   (pixel_ink),
    .final_pixel (final_pixel)
  );

  `BLR_ASSERT_NEXT(a_busy_after_cmd, clk, rst, in_valid && !in_stall, in_stall)
  `BLR_ASSERT_IMP(a_no_cmd_mid_line, clk, rst, out_valid && !final_pixel, in_stall)
  `BLR_ASSERT_NEXT(a_emit_after_cmd, clk, rst, in_valid && !in_stall, !status.out_free || cmd.emit)

endmodule

`default_nettype wire

// ===== tb/sv/bresenham_line_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_tb
// Self-checking bench for the line rasterizer. A directed set of lines
// (points, axis-aligned, diagonals, steep and shallow, relative lines) is
// followed by random line commands under each orientation and several
// idle/stall mixes, including a long output hold-off. A scoreboard walks
// every accepted line itself and checks each pixel write in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ORIENT_NORMAL    = 2'd0;
  localparam logic [1:0] ORIENT_MIRROR_X  = 2'd1;
  localparam logic [1:0] ORIENT_MIRROR_Y  = 2'd2;
  localparam logic [1:0] ORIENT_MIRROR_XY = 2'd3;

  localparam logic KIND_ABSOLUTE = 1'b0;
  localparam logic KIND_RELATIVE = 1'b1;

  localparam int COORD_MAX       = blr_pkg::SCREEN_WIDTH - 1;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 80;
  localparam int LINES_PER_PHASE = 50;

  typedef blr_pkg::coord_t coord_t;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   ink;
  } line_cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   ink;
    logic   last;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = ORIENT_NORMAL;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = 1'b0;
  coord_t     start_x = '0;
  coord_t     start_y = '0;
  coord_t     end_x = '0;
  coord_t     end_y = '0;
  logic       ink = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  coord_t     pixel_x;
  coord_t     pixel_y;
  logic       pixel_ink;
  logic       final_pixel;

  line_cmd_t  line_q[$];
  pixel_t     pixel_q[$];

  logic [1:0] orient_reg = ORIENT_NORMAL;
  coord_t     prev_end_x = '0;
  coord_t     prev_end_y = '0;
  coord_t     gen_end_x = '0;
  coord_t     gen_end_y = '0;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  int         hold_cnt = 0;
  logic       in_took = 1'b0;

  int         errors = 0;
  int         lines_seen = 0;
  int         pixels_seen = 0;
  int         finals_seen = 0;

  bresenham_line_rasterizer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .ink        (ink),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_ink  (pixel_ink),
    .final_pixel(final_pixel)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // walk one line and queue the pixel writes it should produce
  function automatic void predict_pixels(input line_cmd_t c);
    int x, y, ex, ey, dx, dy, step_x, step_y, err, e2;
    logic mirror_x, mirror_y, done;
    pixel_t p;
    mirror_x = (orient_reg == ORIENT_MIRROR_X) || (orient_reg == ORIENT_MIRROR_XY);
    mirror_y = (orient_reg == ORIENT_MIRROR_Y) || (orient_reg == ORIENT_MIRROR_XY);
    x = (c.kind == KIND_RELATIVE) ? int'(prev_end_x) : int'(c.start_x);
    y = (c.kind == KIND_RELATIVE) ? int'(prev_end_y) : int'(c.start_y);
    ex = int'(c.end_x);
    ey = int'(c.end_y);
    prev_end_x = c.end_x;
    prev_end_y = c.end_y;
    dx = (ex > x) ? ex - x : x - ex;
    dy = (ey > y) ? ey - y : y - ey;
    step_x = (x < ex) ? 1 : -1;
    step_y = (y < ey) ? 1 : -1;
    err = dx - dy;
    done = 1'b0;
    while (!done) begin
      done = (x == ex) && (y == ey);
      p.x = mirror_x ? coord_t'(blr_pkg::SCREEN_WIDTH - 1 - x) : coord_t'(x);
      p.y = mirror_y ? coord_t'(blr_pkg::SCREEN_HEIGHT - 1 - y) : coord_t'(y);
      p.ink = c.ink;
      p.last = done;
      pixel_q.push_back(p);
      if (!done) begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += step_x;
        end
        if (e2 < dx) begin
          err += dx;
          y += step_y;
        end
      end
    end
  endfunction

  // scoreboard: check pixel writes, predict accepted lines
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("pixel write (%0d,%0d) with nothing expected",
                                    pixel_x, pixel_y));
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x got %0d expected %0d", pixel_x, want.x));
          if (pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y got %0d expected %0d", pixel_y, want.y));
          if (pixel_ink !== want.ink)
            report_mismatch($sformatf("pixel_ink got %0b expected %0b", pixel_ink, want.ink));
          if (final_pixel !== want.last)
            report_mismatch($sformatf("final_pixel got %0b expected %0b",
                                      final_pixel, want.last));
          if (want.last)
            finals_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        lines_seen++;
        predict_pixels(line_cmd_t'{kind, start_x, start_y, end_x, end_y, ink});
      end
      in_took <= in_valid && !in_stall;
    end
  end

  // command driver
  always @(negedge clk) begin
    line_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (line_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        c = line_q.pop_front();
        in_valid <= 1'b1;
        kind <= c.kind;
        start_x <= c.start_x;
        start_y <= c.start_y;
        end_x <= c.end_x;
        end_y <= c.end_y;
        ink <= c.ink;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // pixel receiver
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_line(input logic k, input int sx, input int sy,
                            input int ex, input int ey, input logic i);
    line_q.push_back(line_cmd_t'{k, coord_t'(sx), coord_t'(sy), coord_t'(ex),
                                 coord_t'(ey), i});
    gen_end_x = coord_t'(ex);
    gen_end_y = coord_t'(ey);
  endtask

  // random lines, biased toward short ones near the start point
  task automatic queue_random_lines(input int n);
    logic k;
    int sx, sy, ex, ey;
    repeat (n) begin
      k = logic'($urandom_range(1));
      sx = $urandom_range(COORD_MAX);
      sy = $urandom_range(COORD_MAX);
      if ($urandom_range(9) < 4) begin
        ex = ((k == KIND_RELATIVE) ? int'(gen_end_x) : sx) + $urandom_range(10) - 5;
        ey = ((k == KIND_RELATIVE) ? int'(gen_end_y) : sy) + $urandom_range(10) - 5;
        ex = (ex < 0) ? 0 : (ex > COORD_MAX) ? COORD_MAX : ex;
        ey = (ey < 0) ? 0 : (ey > COORD_MAX) ? COORD_MAX : ey;
      end else begin
        ex = $urandom_range(COORD_MAX);
        ey = $urandom_range(COORD_MAX);
      end
      queue_line(k, sx, sy, ex, ey, logic'($urandom_range(1)));
    end
  endtask

  // check after the driver's updates for this edge have settled
  task automatic wait_drained(input int extra);
    do begin
      @(negedge clk);
      #1;
    end while (line_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_orientation(input logic [1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    orient_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0] phase_orient[4];
    int phase_idle[4];
    int phase_stall[4];
    phase_orient = '{ORIENT_MIRROR_X, ORIENT_MIRROR_Y, ORIENT_MIRROR_XY, ORIENT_NORMAL};
    phase_idle = '{0, 88, 0, 15};
    phase_stall = '{0, 0, 88, 15};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_orientation(ORIENT_NORMAL);
    queue_line(KIND_ABSOLUTE, 0, 0, 0, 0, 1'b1);
    queue_line(KIND_ABSOLUTE, 63, 63, 63, 63, 1'b0);
    queue_line(KIND_ABSOLUTE, 0, 0, 63, 0, 1'b1);
    queue_line(KIND_RELATIVE, 63, 63, 63, 63, 1'b0);
    queue_line(KIND_RELATIVE, 0, 0, 0, 0, 1'b1);
    queue_line(KIND_ABSOLUTE, 0, 63, 63, 0, 1'b0);
    queue_line(KIND_ABSOLUTE, 10, 5, 14, 40, 1'b1);
    queue_line(KIND_ABSOLUTE, 50, 20, 3, 27, 1'b0);
    queue_line(KIND_RELATIVE, 21, 42, 3, 27, 1'b1);
    queue_line(KIND_RELATIVE, 0, 0, 63, 31, 1'b1);
    queue_line(KIND_ABSOLUTE, 31, 32, 32, 31, 1'b0);
    queue_line(KIND_ABSOLUTE, 0, 0, 1, 1, 1'b1);
    queue_line(KIND_ABSOLUTE, 5, 5, 6, 5, 1'b0);
    queue_line(KIND_RELATIVE, 63, 0, 6, 63, 1'b1);
    queue_line(KIND_ABSOLUTE, 63, 0, 0, 63, 1'b0);
    queue_line(KIND_ABSOLUTE, 42, 21, 21, 42, 1'b1);
    queue_line(KIND_RELATIVE, 42, 42, 42, 21, 1'b0);
    queue_line(KIND_ABSOLUTE, 63, 63, 0, 62, 1'b1);
    queue_line(KIND_ABSOLUTE, 62, 0, 63, 63, 1'b0);
    queue_line(KIND_RELATIVE, 0, 0, 0, 0, 1'b1);
    wait_drained(SETTLE_CYCLES);

    for (int ph = 0; ph < 4; ph++) begin
      write_orientation(phase_orient[ph]);
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      queue_random_lines(LINES_PER_PHASE);
      wait_drained(SETTLE_CYCLES);
    end

    // long output hold-off while commands keep coming
    write_orientation(ORIENT_MIRROR_XY);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_lines(40);
    hold_req = 1'b1;
    wait_drained(DRAIN_CYCLES);

    $display("Ran %0d line commands producing %0d pixel writes (%0d line ends)",
             lines_seen, pixels_seen, finals_seen);
    $display("across all four orientations, idle/stall mixes and an output hold-off");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d pixel writes outstanding", pixel_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
